FILE: rtl/line_follow_steering_macros.svh
// Assertion macros for the line follow steering block.
`ifndef LINE_FOLLOW_STEERING_MACROS_SVH
`define LINE_FOLLOW_STEERING_MACROS_SVH

`ifndef SYNTH
`define LFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LFS_ASSERT(lbl, prop, msg)
`define LFS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: rtl/lfs_pkg.sv
`timescale 1ns / 1ps
package lfs_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int STEP_W = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_HEADING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DAMPING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_COMMAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_POINT_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_POINT_Y  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_ANGLE    = 3'd7;

  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [33:0] Q30_GAIN    = 34'sh026DD3B6A;
  localparam logic signed [19:0] Q16_PI      = 20'sd205887;
  localparam logic signed [19:0] Q16_TWO_PI  = 20'sd411774;
  localparam logic signed [36:0] ETA_LIMIT   = 37'sd26214;
  localparam logic signed [17:0] SPEED_LIMIT = 18'sd65536;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT, ST_SC, ST_MCY, ST_MSX, ST_SUBA, ST_ETA,
    ST_MGD, ST_MGH, ST_MGW, ST_SUBB, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ROT, OP_SC, OP_MCY, OP_MSX, OP_SUB, OP_ETA,
    OP_MGD, OP_MGH, OP_MGW, OP_FIN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'h3243F6A8;
      5'd1:  r = 30'h1DAC6705;
      5'd2:  r = 30'h0FADBAFC;
      5'd3:  r = 30'h07F56EA6;
      5'd4:  r = 30'h03FEAB76;
      5'd5:  r = 30'h01FFD55B;
      5'd6:  r = 30'h00FFFAAA;
      5'd7:  r = 30'h007FFF55;
      5'd8:  r = 30'h003FFFEA;
      5'd9:  r = 30'h001FFFFD;
      5'd10: r = 30'h000FFFFF;
      5'd11: r = 30'h0007FFFF;
      5'd12: r = 30'h0003FFFF;
      5'd13: r = 30'h0001FFFF;
      5'd14: r = 30'h0000FFFF;
      5'd15: r = 30'h00007FFF;
      5'd16: r = 30'h00003FFF;
      5'd17: r = 30'h00001FFF;
      5'd18: r = 30'h00000FFF;
      5'd19: r = 30'h000007FF;
      5'd20: r = 30'h000003FF;
      5'd21: r = 30'h000001FF;
      5'd22: r = 30'h000000FF;
      5'd23: r = 30'h0000007F;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/line_follow_steering.sv
`timescale 1ns / 1ps
// Each input beat is loaded, then passes 16 CORDIC steps and 10 datapath steps before its result beat.
// A new input is taken only once the last one is finished; the shared CORDIC loop and one shared
// 18x33 multiplier allow no overlap. A stalled result holds the block in its final step.
// Reset (rst_n low, synchronous): registers take their defaults, stored turn rate
// clears to zero, no result is pending.
module line_follow_steering import lfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [87:0]           in_tdata,   // pos_x[31:0], pos_y[63:32], heading[82:64]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // forward_speed[17:0], turn_rate[41:18]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  lfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: rtl/lfs_ctrl.sv
`timescale 1ns / 1ps
`include "line_follow_steering_macros.svh"
module lfs_ctrl import lfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    cmd.step  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd.op = OP_ROT;
        if (cnt_r == STEP_W'(CORDIC_ITERS - 1)) begin
          state_nxt = ST_SC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SC: begin
        cmd.op = OP_SC;
        state_nxt = ST_MCY;
      end
      ST_MCY: begin
        cmd.op = OP_MCY;
        state_nxt = ST_MSX;
      end
      ST_MSX: begin
        cmd.op = OP_MSX;
        state_nxt = ST_SUBA;
      end
      ST_SUBA: begin
        cmd.op = OP_SUB;
        state_nxt = ST_ETA;
      end
      ST_ETA: begin
        cmd.op = OP_ETA;
        state_nxt = ST_MGD;
      end
      ST_MGD: begin
        cmd.op = OP_MGD;
        state_nxt = ST_MGH;
      end
      ST_MGH: begin
        cmd.op = OP_MGH;
        state_nxt = ST_MGW;
      end
      ST_MGW: begin
        cmd.op = OP_MGW;
        state_nxt = ST_SUBB;
      end
      ST_SUBB: begin
        cmd.op = OP_SUB;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.op = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `LFS_ASSERT_NEXT(a_accept_rot, in_tvalid && in_tready, state_r == ST_ROT && cnt_r == '0, "accept must start rotation")
  `LFS_ASSERT_NEXT(a_rot_end, state_r == ST_ROT && cnt_r == STEP_W'(CORDIC_ITERS - 1), state_r == ST_SC, "rotation must end after last step")
  `LFS_ASSERT_NEXT(a_fin_idle, state_r == ST_FIN && sts.out_free, state_r == ST_IDLE && in_tready, "finish must return to idle")

endmodule

FILE: rtl/lfs_datapath.sv
`timescale 1ns / 1ps
module lfs_datapath import lfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [87:0]           in_tdata,
  output logic [47:0]           out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  logic [15:0]        gain_distance_r, gain_heading_r, gain_damping_r;
  logic signed [17:0] speed_command_r;
  logic [22:0]        turn_limit_r;
  logic signed [31:0] line_point_x_r, line_point_y_r;
  logic signed [18:0] line_angle_r;

  logic signed [33:0] x_r, y_r;
  logic signed [34:0] z_r;
  logic               neg_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [18:0] phi_r;
  logic signed [17:0] cos_r, sin_r;
  logic signed [15:0] eta_r;
  logic signed [23:0] w0_r;
  logic signed [50:0] prod_r;
  logic signed [52:0] acc_r;
  logic               out_valid_r;
  logic signed [17:0] out_speed_r;
  logic signed [23:0] out_turn_r;

  logic signed [31:0] pos_x, pos_y;
  logic signed [18:0] heading;
  logic signed [34:0] z_init, z_red;
  logic               neg_init;
  logic signed [19:0] phi_raw, phi_wrap;
  logic signed [33:0] x_sh, y_sh, x_fix, y_fix, x_rnd, y_rnd;
  logic signed [34:0] atan_v;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [36:0] eta_full, w_full;
  logic signed [52:0] acc_rnd;
  logic signed [36:0] tl_s;
  logic signed [23:0] w_new;
  logic signed [17:0] speed_clamped;

  assign pos_x   = in_tdata[31:0];
  assign pos_y   = in_tdata[63:32];
  assign heading = in_tdata[82:64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_distance_r <= 16'd5898;
      gain_heading_r  <= 16'd2621;
      gain_damping_r  <= 16'd1966;
      speed_command_r <= 18'sd13107;
      turn_limit_r    <= 23'd411566;
      line_point_x_r  <= '0;
      line_point_y_r  <= '0;
      line_angle_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_DISTANCE: gain_distance_r <= cfg_data[15:0];
        REG_GAIN_HEADING:  gain_heading_r  <= cfg_data[15:0];
        REG_GAIN_DAMPING:  gain_damping_r  <= cfg_data[15:0];
        REG_SPEED_COMMAND: speed_command_r <= cfg_data[17:0];
        REG_TURN_LIMIT:    turn_limit_r    <= cfg_data[22:0];
        REG_LINE_POINT_X:  line_point_x_r  <= cfg_data;
        REG_LINE_POINT_Y:  line_point_y_r  <= cfg_data;
        REG_LINE_ANGLE:    line_angle_r    <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  // angle reduction into [-pi/2, pi/2]
  always_comb begin
    z_init   = {{2{line_angle_r[18]}}, line_angle_r, 14'b0};
    z_red    = z_init;
    neg_init = 1'b0;
    if (z_init > Q30_HALF_PI) begin
      z_red    = z_init - Q30_PI;
      neg_init = 1'b1;
    end else if (z_init < -Q30_HALF_PI) begin
      z_red    = z_init + Q30_PI;
      neg_init = 1'b1;
    end
  end

  always_comb begin
    phi_raw  = 20'(heading) - 20'(line_angle_r);
    phi_wrap = phi_raw;
    if (phi_raw > Q16_PI) begin
      phi_wrap = phi_raw - Q16_TWO_PI;
    end else if (phi_raw <= -Q16_PI) begin
      phi_wrap = phi_raw + Q16_TWO_PI;
    end
  end

  assign x_sh   = x_r >>> cmd.step;
  assign y_sh   = y_r >>> cmd.step;
  assign atan_v = {5'b0, atan_q30(cmd.step)};
  assign x_fix  = neg_r ? -x_r : x_r;
  assign y_fix  = neg_r ? -y_r : y_r;
  assign x_rnd  = x_fix + 34'sd8192;
  assign y_rnd  = y_fix + 34'sd8192;

  always_comb begin
    mul_a = cos_r;
    mul_b = dy_r;
    case (cmd.op)
      OP_MSX: begin
        mul_a = sin_r;
        mul_b = dx_r;
      end
      OP_MGD: begin
        mul_a = {2'b0, gain_distance_r};
        mul_b = 33'(eta_r);
      end
      OP_MGH: begin
        mul_a = {2'b0, gain_heading_r};
        mul_b = 33'(phi_r);
      end
      OP_MGW: begin
        mul_a = {2'b0, gain_damping_r};
        mul_b = 33'(w0_r);
      end
      default: ;
    endcase
  end

  assign eta_full = acc_r[52:16];
  assign acc_rnd  = acc_r + 53'sd32768;
  assign w_full   = acc_rnd[52:16];
  assign tl_s     = {14'b0, turn_limit_r};

  always_comb begin
    if (w_full > tl_s) begin
      w_new = tl_s[23:0];
    end else if (w_full < -tl_s) begin
      w_new = 24'(-tl_s);
    end else begin
      w_new = w_full[23:0];
    end
    if (speed_command_r > SPEED_LIMIT) begin
      speed_clamped = SPEED_LIMIT;
    end else if (speed_command_r < -SPEED_LIMIT) begin
      speed_clamped = -SPEED_LIMIT;
    end else begin
      speed_clamped = speed_command_r;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r   <= Q30_GAIN;
        y_r   <= '0;
        z_r   <= z_red;
        neg_r <= neg_init;
        dx_r  <= 33'(pos_x) - 33'(line_point_x_r);
        dy_r  <= 33'(pos_y) - 33'(line_point_y_r);
        phi_r <= phi_wrap[18:0];
      end
      OP_ROT: begin
        if (!z_r[34]) begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + atan_v;
        end
      end
      OP_SC: begin
        cos_r <= x_rnd[31:14];
        sin_r <= y_rnd[31:14];
      end
      OP_MCY: prod_r <= mul_a * mul_b;
      OP_MSX: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= 53'(prod_r);
      end
      OP_SUB: acc_r <= acc_r - 53'(prod_r);
      OP_ETA: begin
        if (eta_full > ETA_LIMIT) begin
          eta_r <= ETA_LIMIT[15:0];
        end else if (eta_full < -ETA_LIMIT) begin
          eta_r <= 16'(-ETA_LIMIT);
        end else begin
          eta_r <= eta_full[15:0];
        end
      end
      OP_MGD: prod_r <= mul_a * mul_b;
      OP_MGH: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= {{13{w0_r[23]}}, w0_r, 16'b0} - 53'(prod_r);
      end
      OP_MGW: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= acc_r - 53'(prod_r);
      end
      OP_FIN: begin
        out_speed_r <= speed_clamped;
        out_turn_r  <= w_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      w0_r        <= w_new;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {6'b0, out_turn_r, out_speed_r};

endmodule
